@@ sv/ptc_pkg.sv @@
// Shared types, widths and helpers of the patch template classifier.
package ptc_pkg;

    // Default sizes
    localparam int TEMPLATE_COUNT_DEF = 9;
    localparam int PATCH_SIDE_DEF     = 20;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int IDX_W    = 9;
    localparam int PIX_W    = 8;
    localparam int LET_W    = 8;
    localparam int LIM_W    = 17;
    localparam int ACC_W    = 25;
    localparam int SQ_W     = 2 * PIX_W;
    localparam int CFG_W    = 4;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;
    localparam int RES_W    = 1 + LET_W + SLOT_W + ACC_W;

    // Reset value of the active template count
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(9);

    // Symbol reported when nothing matches (space)
    localparam logic [LET_W-1:0] SPACE_CODE = LET_W'(32);

    // Result queue depth; covers every result in flight through the pipeline
    localparam int OUT_DEPTH = 16;

    // Item kinds carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_TPIX  = 2'd0,
        OP_TMETA = 2'd1,
        OP_PATCH = 2'd2
    } op_t;

    // Per-lane pipeline control
    typedef struct packed {
        logic s2_vld;
        logic s2_first;
    } lane_step_t;

    // One candidate of the minimum search
    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
        logic [ACC_W-1:0]  sum;
        logic [LET_W-1:0]  letter;
        logic [LIM_W-1:0]  limit;
    } node_t;

    // Keep the lower-index candidate unless the other one is strictly smaller
    function automatic node_t node_min(node_t lo, node_t hi);
        node_t res;
        res = lo;
        if (hi.vld && (!lo.vld || (hi.sum < lo.sum)))
            res = hi;
        return res;
    endfunction

endpackage

@@ sv/ptc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ptc_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 400,
        localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             wr_en,
        input  logic [AW-1:0]    wr_addr,
        input  logic [WIDTH-1:0] wr_data,
        input  logic [AW-1:0]    rd_addr,
        output logic [WIDTH-1:0] rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ptc_lane.sv @@
// One template lane: template pixel memory, squared difference and error accumulator.
module ptc_lane
    import ptc_pkg::*;
    #(
        parameter int PIXELS = PATCH_SIDE_DEF * PATCH_SIDE_DEF,
        localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             wr_en,
        input  logic [AW-1:0]    wr_addr,
        input  logic [PIX_W-1:0] wr_data,
        input  logic [AW-1:0]    rd_addr,
        input  logic [PIX_W-1:0] s1_pix,
        input  lane_step_t       step,
        output logic [ACC_W-1:0] acc_sum
    );

    logic [PIX_W-1:0] tpix;
    logic [PIX_W-1:0] abs_diff;
    logic [SQ_W-1:0]  sq_reg;
    logic [SQ_W-1:0]  sq_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] base;
    logic [ACC_W:0]   sum_wide;

    ptc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (tpix)
    );

    // Square the absolute pixel difference
    always_comb
    begin
        abs_diff = (s1_pix >= tpix) ? (s1_pix - tpix) : (tpix - s1_pix);
        sq_next  = SQ_W'(abs_diff) * SQ_W'(abs_diff);
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // Add with saturation; the first pixel starts from zero
    always_comb
    begin
        base     = step.s2_first ? '0 : acc_reg;
        sum_wide = {1'b0, base} + (ACC_W + 1)'(sq_reg);
        acc_next = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (step.s2_vld)
            acc_reg <= acc_next;
    end

    assign acc_sum = acc_next;

endmodule

@@ sv/ptc_min_tree.sv @@
// Registered comparison tree that finds the first template with the least error.
module ptc_min_tree
    import ptc_pkg::*;
    #(
        parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF,
        localparam int LVLS          = $clog2(TEMPLATE_COUNT),
        localparam int LEAVES        = 1 << LVLS
    )
    (
        input  logic  clk,
        input  logic  rst_n,
        input  logic  in_valid,
        input  node_t leaf [LEAVES],
        output logic  out_valid,
        output node_t root
    );

    localparam int NODES = 2 * LEAVES - 1;

    node_t node_reg  [NODES];
    node_t node_next [NODES];
    logic [LVLS:0] vld_reg;

    // Leaves load the candidates, inner nodes pick from their children
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            if (i >= LEAVES - 1)
                node_next[i] = leaf[i - (LEAVES - 1)];
            else
                node_next[i] = node_min(node_reg[2 * i + 1], node_reg[2 * i + 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NODES; i++)
            node_reg[i] <= node_next[i];
    end

    // Track which level holds a live search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= (LVLS + 1)'({vld_reg, in_valid});
    end

    assign out_valid = vld_reg[LVLS];
    assign root      = node_reg[0];

endmodule

@@ sv/ptc_out_fifo.sv @@
// Result queue between the pipeline and the output stream.
module ptc_out_fifo
    import ptc_pkg::*;
    #(
        parameter int WIDTH = OUT_W,
        parameter int DEPTH = OUT_DEPTH,
        localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
        localparam int CW   = $clog2(DEPTH + 1)
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        input  logic             push,
        input  logic [WIDTH-1:0] push_data,
        output logic             out_valid,
        input  logic             out_ready,
        output logic [WIDTH-1:0] out_data
    );

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/patch_template_classifier_top.sv @@
// Top level of the patch template classifier.
//
// Input stream s_*: one transfer per item. s_tuser carries the item kind (template pixel,
// template letter and limit, patch pixel); s_tdata carries the slot, pixel index, pixel
// value, letter code and error limit. Patch pixels are compared against every template
// at once, so one item is taken in every cycle while s_tready is high. Pixel 0 clears all
// error sums; the last pixel of the patch yields one result on m_*: match flag, symbol,
// best slot and its squared error sum.
// A result passes stage 1, stage 2, the registered minimum tree, the result stage and the
// result queue before it shows on m_tvalid. Template memories are read in the cycle a
// pixel is taken. Results wait in a 16-entry queue; s_tready drops only when 16 results
// are queued or in flight, so a stalled receiver holds the input only after that many
// patches.
// cfg_*: sets how many templates take part; always ready.
// Reset clears the error sums, the queue and sets 9 active templates. Template pixels,
// letters and limits hold nothing defined until loaded.
module patch_template_classifier_top
    import ptc_pkg::*;
    #(
        parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF,
        parameter int PATCH_SIDE     = PATCH_SIDE_DEF
    )
    (
        input  logic             clk,
        input  logic             rst_n,
        // Input stream
        input  logic             s_tvalid,
        output logic             s_tready,
        input  logic [IN_W-1:0]  s_tdata,  // template_slot, pixel_index, pixel_value,
                                           // letter_code, error_limit, zero pad
        input  logic [OP_W-1:0]  s_tuser,  // op
        // Result stream
        output logic             m_tvalid,
        input  logic             m_tready,
        output logic [OUT_W-1:0] m_tdata,  // matched, symbol, best_slot,
                                           // best_error_sum, zero pad
        // Configuration write
        input  logic             cfg_valid,
        output logic             cfg_ready,
        input  logic [CFG_W-1:0] cfg_data  // active_templates
    );

    localparam int PIXELS = PATCH_SIDE * PATCH_SIDE;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int LVLS   = $clog2(TEMPLATE_COUNT);
    localparam int LEAVES = 1 << LVLS;
    localparam int PXC_W  = $clog2(PIXELS + 1);
    localparam int PROD_W = LIM_W + PXC_W;
    localparam int CMP_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W;
    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    // Input fields
    logic [OP_W-1:0]   in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [IDX_W-1:0]  in_idx;
    logic [PIX_W-1:0]  in_pix;
    logic [LET_W-1:0]  in_letter;
    logic [LIM_W-1:0]  in_limit;
    logic              in_xfer;
    logic              idx_ok;
    logic              patch_xfer;
    logic              last_xfer;
    logic [AW-1:0]     in_addr;

    // Configuration
    logic [CFG_W-1:0]  active_reg;

    // Stage 1 and stage 2 control
    logic              s1_vld_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_meta_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [LET_W-1:0]  s1_letter_reg;
    logic [LIM_W-1:0]  s1_limit_reg;
    logic              s2_vld_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic              s2_meta_reg;
    logic [SLOT_W-1:0] s2_slot_reg;
    logic [LET_W-1:0]  s2_letter_reg;
    logic [LIM_W-1:0]  s2_limit_reg;
    lane_step_t        step;

    // Template letters and limits
    logic [LET_W-1:0]  letter_reg [TEMPLATE_COUNT];
    logic [LIM_W-1:0]  limit_reg  [TEMPLATE_COUNT];

    // Lanes and search
    logic [ACC_W-1:0]  lane_sum [TEMPLATE_COUNT];
    node_t             leaf [LEAVES];
    logic              tree_vld;
    node_t             root;

    // Result stage
    logic              r1_vld_reg;
    node_t             best_reg;
    logic [PROD_W-1:0] lim_px_reg;
    logic              res_matched;
    logic [LET_W-1:0]  res_symbol;
    logic [SLOT_W-1:0] res_slot;
    logic [ACC_W-1:0]  res_sum;
    logic [OUT_W-1:0]  res_data;

    // Output credit
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              out_xfer;

    // Unpack the input transfer
    assign in_op     = s_tuser;
    assign in_slot   = s_tdata[3:0];
    assign in_idx    = s_tdata[12:4];
    assign in_pix    = s_tdata[20:13];
    assign in_letter = s_tdata[28:21];
    assign in_limit  = s_tdata[45:29];

    assign in_xfer    = s_tvalid && s_tready;
    assign idx_ok     = int'(in_idx) < PIXELS;
    assign patch_xfer = in_xfer && (in_op == OP_PATCH) && idx_ok;
    assign last_xfer  = patch_xfer && (int'(in_idx) == PIXELS - 1);
    assign in_addr    = AW'(in_idx);

    assign cfg_ready = 1'b1;
    assign s_tready  = (pending_reg < PEND_W'(OUT_DEPTH));
    assign out_xfer  = m_tvalid && m_tready;

    // Hold the active template count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ACTIVE_RESET;
        else if (cfg_valid && cfg_ready)
            active_reg <= cfg_data;
    end

    // Advance pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_meta_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_meta_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= patch_xfer;
            s1_meta_reg <= in_xfer && (in_op == OP_TMETA) && (int'(in_slot) < TEMPLATE_COUNT);
            s2_vld_reg  <= s1_vld_reg;
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // Carry payload of the two early stages
    always_ff @(posedge clk)
    begin
        s1_first_reg  <= (in_idx == '0);
        s1_last_reg   <= last_xfer;
        s1_pix_reg    <= in_pix;
        s1_slot_reg   <= in_slot;
        s1_letter_reg <= in_letter;
        s1_limit_reg  <= in_limit;
        s2_first_reg  <= s1_first_reg;
        s2_last_reg   <= s1_last_reg;
        s2_slot_reg   <= s1_slot_reg;
        s2_letter_reg <= s1_letter_reg;
        s2_limit_reg  <= s1_limit_reg;
    end

    assign step.s2_vld   = s2_vld_reg;
    assign step.s2_first = s2_first_reg;

    // Write letters and limits in order with the accumulation stage
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TEMPLATE_COUNT; t++)
        begin
            if (s2_meta_reg && (s2_slot_reg == SLOT_W'(t)))
            begin
                letter_reg[t] <= s2_letter_reg;
                limit_reg[t]  <= s2_limit_reg;
            end
        end
    end

    // One lane per template
    for (genvar t = 0; t < TEMPLATE_COUNT; t++)
    begin : g_lane
        logic lane_wr;

        assign lane_wr = in_xfer && (in_op == OP_TPIX) && idx_ok &&
                         (in_slot == SLOT_W'(t));

        ptc_lane #(
            .PIXELS (PIXELS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (lane_wr),
            .wr_addr (in_addr),
            .wr_data (in_pix),
            .rd_addr (in_addr),
            .s1_pix  (s1_pix_reg),
            .step    (step),
            .acc_sum (lane_sum[t])
        );
    end

    // Build search candidates from the final sums
    always_comb
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            leaf[j] = '0;
            if (j < TEMPLATE_COUNT)
            begin
                leaf[j].vld    = int'(active_reg) > j;
                leaf[j].slot   = SLOT_W'(j);
                leaf[j].sum    = lane_sum[j];
                leaf[j].letter = letter_reg[j];
                leaf[j].limit  = limit_reg[j];
            end
        end
    end

    ptc_min_tree #(
        .TEMPLATE_COUNT (TEMPLATE_COUNT)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg && s2_last_reg),
        .leaf      (leaf),
        .out_valid (tree_vld),
        .root      (root)
    );

    // Scale the winner's limit by the pixel count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_vld_reg <= 1'b0;
        else
            r1_vld_reg <= tree_vld;
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= root;
        lim_px_reg <= PROD_W'(root.limit) * PROD_W'(PIXELS);
    end

    // Compare and form the result
    always_comb
    begin
        res_matched = best_reg.vld && (CMP_W'(best_reg.sum) < CMP_W'(lim_px_reg));
        res_symbol  = res_matched ? best_reg.letter : SPACE_CODE;
        res_slot    = best_reg.vld ? best_reg.slot : '0;
        res_sum     = best_reg.vld ? best_reg.sum : '0;
        res_data    = OUT_W'({res_sum, res_slot, res_symbol, res_matched});
    end

    ptc_out_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (r1_vld_reg),
        .push_data (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Count results in flight or queued
    always_comb
    begin
        pending_next = pending_reg;
        if (last_xfer && !out_xfer)
            pending_next = pending_reg + 1'b1;
        else if (!last_xfer && out_xfer)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // Checks
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("result credit count above queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != '0))
        else $error("result shown with no credit outstanding");

    a_push_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        r1_vld_reg |-> (pending_reg != '0))
        else $error("result produced with no last pixel outstanding");

    a_last_reaches_tree: assert property (@(posedge clk) disable iff (!rst_n)
        last_xfer |=> ##1 (s2_vld_reg && s2_last_reg))
        else $error("last pixel lost before the search");

endmodule
